@@ rtl/gbmd_pkg.sv @@
`default_nettype none

package gbmd_pkg;

  // field widths of the channels
  localparam int unsigned CellW      = 8;
  localparam int unsigned IndexW     = 16;
  localparam int unsigned WallW      = 17;

  // configuration register widths
  localparam int unsigned BlockCfgW  = 5;
  localparam int unsigned FineCfgW   = 13;
  localparam int unsigned CoarseCfgW = 9;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 13;

  // per-column occupied count, wraps at this width
  localparam int unsigned CntW       = 9;

  // coarse row limit and the row counter that must also hold the limit itself
  localparam int unsigned CoarseHLimit = 256;
  localparam int unsigned RowW         = 9;

  localparam logic [CellW-1:0] Occupied = 8'd100;

  // register reset values
  localparam logic [BlockCfgW-1:0]  BlockWRst  = 5'd10;
  localparam logic [BlockCfgW-1:0]  BlockHRst  = 5'd10;
  localparam logic [FineCfgW-1:0]   FineWRst   = 13'd2560;
  localparam logic [CoarseCfgW-1:0] CoarseWRst = 9'd256;
  localparam logic [CoarseCfgW-1:0] CoarseHRst = 9'd256;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_W       = 3'd0,
    CFG_BLOCK_H       = 3'd1,
    CFG_FINE_WIDTH    = 3'd2,
    CFG_COARSE_WIDTH  = 3'd3,
    CFG_COARSE_HEIGHT = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [IndexW-1:0] coarse_index;
    logic              is_wall;
    logic [WallW-1:0]  wall_total;
    logic              grid_done;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/gbmd_intf.sv @@
`default_nettype none

interface gbmd_in_if;
  import gbmd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CellW-1:0] cell_value;
  logic                    frame_start;

  modport source (output valid, output cell_value, output frame_start, input ready);
  modport sink   (input valid, input cell_value, input frame_start, output ready);
endinterface

interface gbmd_out_if;
  import gbmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [IndexW-1:0] coarse_index;
  logic              is_wall;
  logic [WallW-1:0]  wall_total;
  logic              grid_done;

  modport source (output valid, output coarse_index, output is_wall, output wall_total,
                  output grid_done, input ready);
  modport sink   (input valid, input coarse_index, input is_wall, input wall_total,
                  input grid_done, output ready);
endinterface

interface gbmd_cfg_if;
  import gbmd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/grid_block_majority_downsample_unit.sv @@
`default_nettype none

// channel  | role   | payload
// ---------+--------+---------------------------------------------------
// cell_i   | sink   | cell_value (signed 8), frame_start
// res_o    | source | coarse_index (16), is_wall, wall_total (17), grid_done
// cfg_i    | sink   | index (3), data (13); always ready
//
// one cell request per clock while cell_i.ready is high; the column count memory is
// read on accept and written back in the following cycle, so the read-modify-write
// pipeline sets the rate; a result passes the update stage and the result buffer
// before it shows at res_o; after reset a clearing pass zeroes the count memory
// with cell_i.ready low; configuration writes are taken during it
// results queue in a two-entry buffer; cell_i.ready drops when the buffer and the
// update stage together hold two requests and no result leaves in that cycle

module grid_block_majority_downsample_unit #(
  parameter int unsigned MAX_COARSE_WIDTH = 256,
  parameter int unsigned MAX_BLOCK        = 16,
  parameter int unsigned MAX_FINE_WIDTH   = 4096
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  gbmd_in_if.sink   cell_i,
  gbmd_out_if.source res_o,
  gbmd_cfg_if.sink  cfg_i
);
  import gbmd_pkg::*;

  // counter widths (value below the limit) and clamped value widths (limit itself)
  localparam int unsigned FxW  = (MAX_FINE_WIDTH > 1) ? $clog2(MAX_FINE_WIDTH) : 1;
  localparam int unsigned BiW  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int unsigned CcW  = (MAX_COARSE_WIDTH > 1) ? $clog2(MAX_COARSE_WIDTH) : 1;
  localparam int unsigned BvW  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned CwvW = $clog2(MAX_COARSE_WIDTH + 1);
  localparam int unsigned PW   = CwvW + BvW;
  localparam int unsigned CmpW = (FxW > PW) ? FxW : PW;
  localparam int unsigned AW0  = 2 * BvW;
  localparam int unsigned AW   = (AW0 > CntW + 1) ? AW0 : CntW + 1;
  localparam int unsigned IW0  = RowW + CwvW + 1;
  localparam int unsigned IW   = (IW0 > IndexW) ? IW0 : IndexW;

  // configuration registers
  logic [BlockCfgW-1:0]  block_w_q, block_h_q;
  logic [FineCfgW-1:0]   fine_w_q;
  logic [CoarseCfgW-1:0] coarse_w_q, coarse_h_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_w_q  <= BlockWRst;
      block_h_q  <= BlockHRst;
      fine_w_q   <= FineWRst;
      coarse_w_q <= CoarseWRst;
      coarse_h_q <= CoarseHRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_BLOCK_W:       block_w_q  <= cfg_i.data[BlockCfgW-1:0];
        CFG_BLOCK_H:       block_h_q  <= cfg_i.data[BlockCfgW-1:0];
        CFG_FINE_WIDTH:    fine_w_q   <= cfg_i.data[FineCfgW-1:0];
        CFG_COARSE_WIDTH:  coarse_w_q <= cfg_i.data[CoarseCfgW-1:0];
        CFG_COARSE_HEIGHT: coarse_h_q <= cfg_i.data[CoarseCfgW-1:0];
        default: ;
      endcase
    end
  end

  // saturated register values, minus one, so zero acts as one
  logic [BiW-1:0]  bw_m1, bh_m1;
  logic [FxW-1:0]  fw_m1;
  logic [CcW-1:0]  cw_m1;
  logic [RowW-1:0] ch_m1;
  logic [BvW-1:0]  bw, bh;
  logic [CwvW-1:0] cw;
  logic [PW-1:0]   cover_w;
  logic [AW0-1:0]  area;

  always_comb begin
    if (block_w_q == '0) bw_m1 = '0;
    else if (block_w_q > MAX_BLOCK) bw_m1 = BiW'(MAX_BLOCK - 1);
    else bw_m1 = BiW'(block_w_q - 1'b1);

    if (block_h_q == '0) bh_m1 = '0;
    else if (block_h_q > MAX_BLOCK) bh_m1 = BiW'(MAX_BLOCK - 1);
    else bh_m1 = BiW'(block_h_q - 1'b1);

    if (fine_w_q == '0) fw_m1 = '0;
    else if (fine_w_q > MAX_FINE_WIDTH) fw_m1 = FxW'(MAX_FINE_WIDTH - 1);
    else fw_m1 = FxW'(fine_w_q - 1'b1);

    if (coarse_w_q == '0) cw_m1 = '0;
    else if (coarse_w_q > MAX_COARSE_WIDTH) cw_m1 = CcW'(MAX_COARSE_WIDTH - 1);
    else cw_m1 = CcW'(coarse_w_q - 1'b1);

    if (coarse_h_q == '0) ch_m1 = '0;
    else if (coarse_h_q > CoarseHLimit) ch_m1 = RowW'(CoarseHLimit - 1);
    else ch_m1 = RowW'(coarse_h_q - 1'b1);

    bw      = BvW'(bw_m1) + 1'b1;
    bh      = BvW'(bh_m1) + 1'b1;
    cw      = CwvW'(cw_m1) + 1'b1;
    cover_w = PW'(cw) * PW'(bw);
    area    = AW0'(bw) * AW0'(bh);
  end

  // position state
  logic [FxW-1:0]  fine_x_q, fine_x_d;
  logic [BiW-1:0]  row_in_q, row_in_d;
  logic [BiW-1:0]  col_in_q, col_in_d;
  logic [CcW-1:0]  ccol_q, ccol_d;
  logic [RowW-1:0] crow_q, crow_d;
  logic [WallW-1:0] wall_q, wall_d;

  // clearing pass
  logic           clr_active_q;
  logic [CcW-1:0] clr_addr_q;

  // read-modify-write stage
  logic              s1_valid_q, s1_fs_q, s1_write_q, s1_first_q, s1_occ_q;
  logic              s1_emit_q, s1_last_q;
  logic [CcW-1:0]    s1_addr_q;
  logic [IndexW-1:0] s1_index_q;
  logic [AW0-1:0]    s1_area_q;

  // result buffer
  result_t    fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fifo_cnt_q;
  logic       push, pop;

  logic accept;
  logic [2:0] occupancy;

  assign pop       = res_o.valid && res_o.ready;
  assign occupancy = 3'(fifo_cnt_q) + 3'(s1_valid_q);
  assign cell_i.ready = !clr_active_q && ((occupancy < 3'd2) || (occupancy == 3'd2 && pop));
  assign accept    = cell_i.valid && cell_i.ready;

  // stage 0: position update, memory read address
  logic           fs, occ, active, in_cover, first, emit, last;
  logic [FxW-1:0] x0, fx;
  logic [BiW-1:0] rib0, cib0, rb, cb;
  logic [CcW-1:0] cc0, cc;
  logic [RowW-1:0] row0;
  logic [IW-1:0]  idx_full;

  always_comb begin
    fs   = cell_i.frame_start;
    occ  = (cell_i.cell_value == Occupied);
    x0   = fs ? '0 : fine_x_q;
    rib0 = fs ? '0 : row_in_q;
    cib0 = fs ? '0 : col_in_q;
    cc0  = fs ? '0 : ccol_q;
    row0 = fs ? '0 : crow_q;

    fx = (x0 > fw_m1) ? fw_m1 : x0;
    rb = (rib0 > bh_m1) ? bh_m1 : rib0;
    cb = (cib0 > bw_m1) ? bw_m1 : cib0;
    cc = (cc0 > cw_m1) ? cw_m1 : cc0;

    active   = (row0 <= ch_m1);
    in_cover = active && (CmpW'(fx) < CmpW'(cover_w));
    first    = (rb == '0) && (cb == '0);
    emit     = in_cover && (rb == bh_m1) && (cb == bw_m1);
    last     = (cc == cw_m1) && (row0 == ch_m1);

    idx_full = IW'(row0) * IW'(cw) + IW'(cc);

    fine_x_d = fine_x_q;
    row_in_d = row_in_q;
    col_in_d = col_in_q;
    ccol_d   = ccol_q;
    crow_d   = crow_q;

    if (active) begin
      fine_x_d = fx;
      row_in_d = rb;
      col_in_d = cb;
      ccol_d   = cc;
      crow_d   = row0;
      if (in_cover) begin
        if (cb == bw_m1) begin
          col_in_d = '0;
          if (cc < cw_m1) ccol_d = cc + 1'b1;
        end else begin
          col_in_d = cb + 1'b1;
        end
      end
      if (fx == fw_m1) begin
        fine_x_d = '0;
        col_in_d = '0;
        ccol_d   = '0;
        if (rb == bh_m1) begin
          row_in_d = '0;
          crow_d   = row0 + 1'b1;
        end else begin
          row_in_d = rb + 1'b1;
        end
      end else begin
        fine_x_d = fx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fine_x_q <= '0;
      row_in_q <= '0;
      col_in_q <= '0;
      ccol_q   <= '0;
      crow_q   <= '0;
    end else if (accept) begin
      fine_x_q <= fine_x_d;
      row_in_q <= row_in_d;
      col_in_q <= col_in_d;
      ccol_q   <= ccol_d;
      crow_q   <= crow_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_fs_q    <= fs;
      s1_write_q <= in_cover;
      s1_first_q <= first;
      s1_occ_q   <= occ;
      s1_emit_q  <= emit;
      s1_last_q  <= last;
      s1_addr_q  <= cc;
      s1_index_q <= idx_full[IndexW-1:0];
      s1_area_q  <= area;
    end
  end

  // column count memory
  logic [CntW-1:0] col_cnt_q [MAX_COARSE_WIDTH];
  logic [CntW-1:0] rdata_q;
  logic            mem_we;
  logic [CcW-1:0]  mem_wa;
  logic [CntW-1:0] mem_wd;

  always_ff @(posedge clk_i) begin
    if (accept && in_cover) rdata_q <= col_cnt_q[cc];
    if (mem_we) col_cnt_q[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == CcW'(MAX_COARSE_WIDTH - 1)) clr_active_q <= 1'b0;
    end
  end

  // stage 1: count update with forwarding of the write from the cycle before
  logic            fwd_valid_q;
  logic [CcW-1:0]  fwd_addr_q;
  logic [CntW-1:0] fwd_cnt_q;
  logic [CntW-1:0] base, cnt;
  logic            s1_wr, wall;
  result_t         res;

  always_comb begin
    s1_wr = s1_valid_q && s1_write_q;
    if (s1_first_q) base = '0;
    else if (fwd_valid_q && fwd_addr_q == s1_addr_q) base = fwd_cnt_q;
    else base = rdata_q;
    cnt  = base + CntW'(s1_occ_q);
    wall = (AW'({cnt, 1'b0}) >= AW'(s1_area_q));

    wall_d = (s1_fs_q ? '0 : wall_q) + WallW'(s1_emit_q && wall);

    mem_we = clr_active_q || s1_wr;
    mem_wa = clr_active_q ? clr_addr_q : s1_addr_q;
    mem_wd = clr_active_q ? '0 : cnt;

    res.coarse_index = s1_index_q;
    res.is_wall      = wall;
    res.wall_total   = wall_d;
    res.grid_done    = s1_last_q;
  end

  assign push = s1_valid_q && s1_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_q      <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (s1_valid_q) wall_q <= wall_d;
      fwd_valid_q <= s1_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      fwd_addr_q <= s1_addr_q;
      fwd_cnt_q  <= cnt;
    end
  end

  // result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      fifo_cnt_q <= fifo_cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= res;
  end

  assign res_o.valid        = (fifo_cnt_q != '0);
  assign res_o.coarse_index = fifo_q[rd_ptr_q].coarse_index;
  assign res_o.is_wall      = fifo_q[rd_ptr_q].is_wall;
  assign res_o.wall_total   = fifo_q[rd_ptr_q].wall_total;
  assign res_o.grid_done    = fifo_q[rd_ptr_q].grid_done;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && fifo_cnt_q == 2'd2 |-> pop)
    else $error("result buffer overflow");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !accept)
    else $error("request accepted during clearing pass");

  a_stage_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(accept))
    else $error("update stage without accepted request");

  a_emit_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_emit_q |-> s1_write_q)
    else $error("result from a cell outside coverage");

  a_wall_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fs_q && !clr_active_q |=> wall_q == $past(wall_q) ||
      wall_q == $past(wall_q) + 1'b1)
    else $error("wall total moved by more than one");
`endif

endmodule

`default_nettype wire

@@ dv/grid_block_majority_downsample_unit_tb.sv @@
module grid_block_majority_downsample_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbmd_pkg::*;

  localparam int unsigned MaxBlock    = 16;
  localparam int unsigned MaxFineW    = 4096;
  localparam int unsigned MaxCoarseW  = 256;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned RandItems   = 600;
  localparam int unsigned CalmFrom    = 500;
  localparam int unsigned RegW [5] = '{BlockCfgW, BlockCfgW, FineCfgW, CoarseCfgW, CoarseCfgW};

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_CELL,
    ROW_CELL_RES,
    ROW_CELL_QUIET
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  cfg_sel;
    logic [CfgDataW-1:0] cfg_data;
    logic [CellW-1:0]    value;
    logic                fs;
    result_t             want;
  } stim_row_t;

  localparam result_t NoResult  = '0;
  localparam result_t OneWall   = {16'd0, 1'b1, 17'd1, 1'b1};
  localparam result_t OneClear  = {16'd0, 1'b0, 17'd0, 1'b1};
  localparam int unsigned DirRows = 38;

  localparam stim_row_t DirTab [DirRows] = '{
    // one fine cell per block, one block per grid
    '{ROW_CFG, CFG_BLOCK_W,       13'd1, 8'h00, 1'b0, NoResult},
    '{ROW_CFG, CFG_BLOCK_H,       13'd1, 8'h00, 1'b0, NoResult},
    '{ROW_CFG, CFG_FINE_WIDTH,    13'd1, 8'h00, 1'b0, NoResult},
    '{ROW_CFG, CFG_COARSE_WIDTH,  13'd1, 8'h00, 1'b0, NoResult},
    '{ROW_CFG, CFG_COARSE_HEIGHT, 13'd1, 8'h00, 1'b0, NoResult},
    '{ROW_CELL_RES,   3'd0, 13'd0, 8'd100, 1'b1, OneWall},
    '{ROW_CELL_RES,   3'd0, 13'd0, 8'h7F,  1'b1, OneClear},
    // past the last coarse row until the next frame start
    '{ROW_CELL_QUIET, 3'd0, 13'd0, 8'h80,  1'b0, NoResult},
    '{ROW_CELL_QUIET, 3'd0, 13'd0, 8'd100, 1'b0, NoResult},
    '{ROW_CELL_RES,   3'd0, 13'd0, 8'd100, 1'b1, OneWall},
    '{ROW_CELL_RES,   3'd0, 13'd0, 8'd99,  1'b1, OneClear},
    '{ROW_CELL_RES,   3'd0, 13'd0, 8'd101, 1'b1, OneClear},
    '{ROW_CELL_RES,   3'd0, 13'd0, 8'h9C,  1'b1, OneClear},
    '{ROW_CELL_RES,   3'd0, 13'd0, 8'h00,  1'b1, OneClear},
    '{ROW_CELL_RES,   3'd0, 13'd0, 8'hFF,  1'b1, OneClear},
    // 2x2 blocks, two per row, one fine cell right of coverage
    '{ROW_CFG, CFG_BLOCK_W,       13'd2, 8'h00, 1'b0, NoResult},
    '{ROW_CFG, CFG_BLOCK_H,       13'd2, 8'h00, 1'b0, NoResult},
    '{ROW_CFG, CFG_FINE_WIDTH,    13'd5, 8'h00, 1'b0, NoResult},
    '{ROW_CFG, CFG_COARSE_WIDTH,  13'd2, 8'h00, 1'b0, NoResult},
    '{ROW_CFG, CFG_COARSE_HEIGHT, 13'd1, 8'h00, 1'b0, NoResult},
    '{ROW_CELL, 3'd0, 13'd0, 8'd100, 1'b1, NoResult},
    '{ROW_CELL, 3'd0, 13'd0, 8'd100, 1'b0, NoResult},
    '{ROW_CELL, 3'd0, 13'd0, 8'd0,   1'b0, NoResult},
    '{ROW_CELL, 3'd0, 13'd0, 8'd0,   1'b0, NoResult},
    '{ROW_CELL, 3'd0, 13'd0, 8'd100, 1'b0, NoResult},
    '{ROW_CELL, 3'd0, 13'd0, 8'd0,   1'b0, NoResult},
    '{ROW_CELL, 3'd0, 13'd0, 8'd100, 1'b0, NoResult},
    // second block exactly half occupied
    '{ROW_CELL, 3'd0, 13'd0, 8'd100, 1'b0, NoResult},
    '{ROW_CELL, 3'd0, 13'd0, 8'd100, 1'b0, NoResult},
    '{ROW_CELL, 3'd0, 13'd0, 8'hFF,  1'b0, NoResult},
    '{ROW_CELL, 3'd0, 13'd0, 8'd100, 1'b0, NoResult},
    // out-of-range registers saturate, zero acts as one
    '{ROW_CFG, CFG_BLOCK_W,       13'd31,   8'h00, 1'b0, NoResult},
    '{ROW_CFG, CFG_BLOCK_H,       13'd0,    8'h00, 1'b0, NoResult},
    '{ROW_CFG, CFG_FINE_WIDTH,    13'd8191, 8'h00, 1'b0, NoResult},
    '{ROW_CFG, CFG_COARSE_WIDTH,  13'd511,  8'h00, 1'b0, NoResult},
    '{ROW_CFG, CFG_COARSE_HEIGHT, 13'd511,  8'h00, 1'b0, NoResult},
    '{ROW_CELL_QUIET, 3'd0, 13'd0, 8'd100, 1'b1, NoResult},
    '{ROW_CELL_QUIET, 3'd0, 13'd0, 8'h80,  1'b0, NoResult}
  };

  logic clk_i;
  logic rst_ni;

  gbmd_in_if  cell_if ();
  gbmd_out_if res_if ();
  gbmd_cfg_if cfg_if ();

  grid_block_majority_downsample_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cell_i (cell_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // downsampler state as the block should hold it
  logic [BlockCfgW-1:0]  blk_w_reg  = BlockWRst;
  logic [BlockCfgW-1:0]  blk_h_reg  = BlockHRst;
  logic [FineCfgW-1:0]   fine_w_reg = FineWRst;
  logic [CoarseCfgW-1:0] crs_w_reg  = CoarseWRst;
  logic [CoarseCfgW-1:0] crs_h_reg  = CoarseHRst;
  logic [CntW-1:0]       col_count [MaxCoarseW] = '{default: '0};
  logic [11:0]           fx    = '0;
  logic [3:0]            rib   = '0;
  logic [3:0]            cib   = '0;
  logic [7:0]            ccol  = '0;
  logic [RowW-1:0]       crow  = '0;
  logic [WallW-1:0]      walls = '0;

  result_t     due_blocks [$];
  row_kind_e   cell_mode;
  result_t     cell_want;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  function automatic void queue_block(input result_t blk);
    due_blocks.insert(due_blocks.size(), blk);
  endfunction

  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit fold_cell(input logic [CellW-1:0] value, input logic fs,
                                   output result_t res);
    int unsigned bw, bh, fw, cw, ch, cnt;
    logic wall;
    bit emit;
    bw = clamp_reg(blk_w_reg, MaxBlock);
    bh = clamp_reg(blk_h_reg, MaxBlock);
    fw = clamp_reg(fine_w_reg, MaxFineW);
    cw = clamp_reg(crs_w_reg, MaxCoarseW);
    ch = clamp_reg(crs_h_reg, CoarseHLimit);
    res = '0;
    emit = 1'b0;
    if (fs) begin
      fx = '0;
      rib = '0;
      cib = '0;
      ccol = '0;
      crow = '0;
      walls = '0;
    end
    if (crow >= ch) return 1'b0;
    // registers may have shrunk under a running grid
    if (fx >= fw) fx = 12'(fw - 1);
    if (rib >= bh) rib = 4'(bh - 1);
    if (cib >= bw) cib = 4'(bw - 1);
    if (ccol >= cw) ccol = 8'(cw - 1);
    if (fx < cw * bw) begin
      // first cell of a block overwrites the column count
      cnt = (rib == 0 && cib == 0) ? 0 : col_count[ccol];
      if (value == Occupied) cnt++;
      cnt = cnt % (1 << CntW);
      col_count[ccol] = CntW'(cnt);
      if (rib == bh - 1 && cib == bw - 1) begin
        wall = (2 * cnt >= bw * bh);
        walls = walls + wall;
        res.coarse_index = IndexW'(crow * cw + ccol);
        res.is_wall = wall;
        res.wall_total = walls;
        res.grid_done = (ccol == cw - 1 && crow == ch - 1);
        emit = 1'b1;
      end
      if (cib == bw - 1) begin
        cib = '0;
        if (ccol < cw - 1) ccol++;
      end else begin
        cib++;
      end
    end
    if (fx == fw - 1) begin
      fx = '0;
      cib = '0;
      ccol = '0;
      if (rib == bh - 1) begin
        rib = '0;
        crow++;
      end else begin
        rib++;
      end
    end else begin
      fx++;
    end
    return emit;
  endfunction

  function automatic int unsigned pick_block_size();
    if ($urandom_range(0, 4) != 0) return $urandom_range(1, 3);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return MaxBlock;
      2: return 31;
      default: return $urandom_range(0, 31);
    endcase
  endfunction

  function automatic int unsigned pick_coarse_size(input int unsigned hi_small);
    if ($urandom_range(0, 4) != 0) return $urandom_range(1, hi_small);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return MaxCoarseW;
      2: return 511;
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side back-pressure
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < stall_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want, got;
    bit emitted;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_BLOCK_W:       blk_w_reg  = cfg_if.data[BlockCfgW-1:0];
          CFG_BLOCK_H:       blk_h_reg  = cfg_if.data[BlockCfgW-1:0];
          CFG_FINE_WIDTH:    fine_w_reg = cfg_if.data[FineCfgW-1:0];
          CFG_COARSE_WIDTH:  crs_w_reg  = cfg_if.data[CoarseCfgW-1:0];
          CFG_COARSE_HEIGHT: crs_h_reg  = cfg_if.data[CoarseCfgW-1:0];
          default: ;
        endcase
      end
      if (cell_if.valid && cell_if.ready) begin
        emitted = fold_cell(cell_if.cell_value, cell_if.frame_start, want);
        if (cell_mode == ROW_CELL_RES) queue_block(cell_want);
        else if (cell_mode == ROW_CELL && emitted) queue_block(want);
      end
      if (res_if.valid && res_if.ready) begin
        got = {res_if.coarse_index, res_if.is_wall, res_if.wall_total, res_if.grid_done};
        if (due_blocks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected block result index %0d wall %0b total %0d done %0b",
                     $realtime, got.coarse_index, got.is_wall, got.wall_total, got.grid_done);
        end else begin
          want = due_blocks.pop_front();
          if (got.coarse_index !== want.coarse_index || got.is_wall !== want.is_wall ||
              got.wall_total !== want.wall_total || got.grid_done !== want.grid_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: block mismatch, expected index %0d wall %0b total %0d done %0b, %s",
                       $realtime, want.coarse_index, want.is_wall, want.wall_total,
                       want.grid_done,
                       $sformatf("got index %0d wall %0b total %0d done %0b",
                                 got.coarse_index, got.is_wall, got.wall_total,
                                 got.grid_done));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cell_if.valid && cell_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IdleLimit) begin
      $display("grid_block_majority_downsample_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cell(input logic [CellW-1:0] value, input logic fs,
                           input row_kind_e mode, input result_t want);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < gap_pct) begin
      cell_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    cell_mode = mode;
    cell_want = want;
    cell_if.valid <= 1'b1;
    cell_if.cell_value <= value;
    cell_if.frame_start <= fs;
    do @(posedge clk_i); while (!(cell_if.valid && cell_if.ready));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // no request in flight and every finished block delivered
  task automatic wait_grid_idle();
    @(negedge clk_i);
    cell_if.valid <= 1'b0;
    while (due_blocks.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    int unsigned cfg_raw [5];
    bit          wr [5];
    bit          first_phase, big_block, calm;
    int unsigned rand_items, n, density, bw_e, cw_e;

    rst_ni = 1'b0;
    cell_if.valid = 1'b0;
    cell_if.cell_value = '0;
    cell_if.frame_start = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    cell_mode = ROW_CELL;
    cell_want = NoResult;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    gap_pct = 20;
    stall_pct = 20;
    for (int i = 0; i < DirRows; i++) begin
      if (DirTab[i].kind == ROW_CFG) begin
        if (i == 0 || DirTab[i-1].kind != ROW_CFG) wait_grid_idle();
        write_reg(DirTab[i].cfg_sel, DirTab[i].cfg_data);
      end else begin
        send_cell(DirTab[i].value, DirTab[i].fs, DirTab[i].kind, DirTab[i].want);
      end
    end

    cfg_raw = '{BlockWRst, BlockHRst, FineWRst, CoarseWRst, CoarseHRst};
    first_phase = 1'b1;
    rand_items = 0;
    while (rand_items < RandItems) begin
      wait_grid_idle();
      calm = (rand_items >= CalmFrom);
      gap_pct = calm ? 0 : 20 * $urandom_range(0, 2);
      stall_pct = calm ? 0 : 20 * $urandom_range(0, 2);
      big_block = ($urandom_range(0, 9) == 0);
      for (int r = 0; r < 5; r++) wr[r] = first_phase || big_block || $urandom_range(0, 9) < 7;
      first_phase = 1'b0;

      if (wr[CFG_BLOCK_W]) cfg_raw[CFG_BLOCK_W] = big_block ? MaxBlock : pick_block_size();
      if (wr[CFG_BLOCK_H])
        cfg_raw[CFG_BLOCK_H] = big_block ? $urandom_range(1, MaxBlock) : pick_block_size();
      if (wr[CFG_COARSE_WIDTH])
        cfg_raw[CFG_COARSE_WIDTH] = big_block ? 1 : pick_coarse_size(3);
      if (wr[CFG_COARSE_HEIGHT])
        cfg_raw[CFG_COARSE_HEIGHT] = big_block ? 1 : pick_coarse_size(2);
      bw_e = clamp_reg(cfg_raw[CFG_BLOCK_W] % (1 << BlockCfgW), MaxBlock);
      cw_e = clamp_reg(cfg_raw[CFG_COARSE_WIDTH] % (1 << CoarseCfgW), MaxCoarseW);
      if (wr[CFG_FINE_WIDTH]) begin
        if (!big_block && $urandom_range(0, 6) == 0) begin
          case ($urandom_range(0, 3))
            0: cfg_raw[CFG_FINE_WIDTH] = 0;
            1: cfg_raw[CFG_FINE_WIDTH] = MaxFineW;
            2: cfg_raw[CFG_FINE_WIDTH] = 8191;
            default: cfg_raw[CFG_FINE_WIDTH] = $urandom_range(0, 8191);
          endcase
        end else begin
          // coverage edge: one short, exact, or a little past the fine row
          cfg_raw[CFG_FINE_WIDTH] = cw_e * bw_e + $urandom_range(0, 3) - 1;
        end
      end
      for (int r = CFG_BLOCK_W; r <= CFG_COARSE_HEIGHT; r++)
        if (wr[r]) write_reg(CfgIdxW'(r), CfgDataW'(cfg_raw[r] | ($urandom << RegW[r])));
      if ($urandom_range(0, 9) == 0)
        write_reg(CfgIdxW'(CFG_COARSE_HEIGHT + $urandom_range(1, 3)), CfgDataW'($urandom));

      if ($urandom_range(0, 99) < 85) begin
        n = clamp_reg(cfg_raw[CFG_FINE_WIDTH], MaxFineW) *
            clamp_reg(cfg_raw[CFG_BLOCK_H] % (1 << BlockCfgW), MaxBlock) *
            clamp_reg(cfg_raw[CFG_COARSE_HEIGHT] % (1 << CoarseCfgW), CoarseHLimit) +
            $urandom_range(0, 3);
        if (n > (big_block ? 300 : 120)) n = big_block ? 300 : 120;
        if (n > RandItems - rand_items) n = RandItems - rand_items;
        density = 25 * $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
          send_cell(($urandom_range(0, 99) < density) ? Occupied : CellW'($urandom),
                    i == 0 || $urandom_range(0, 199) == 0, ROW_CELL, NoResult);
      end else begin
        // loose cells into whatever grid position the block holds
        n = $urandom_range(10, 40);
        if (n > RandItems - rand_items) n = RandItems - rand_items;
        for (int i = 0; i < n; i++)
          send_cell(($urandom_range(0, 9) < 3) ? Occupied : CellW'($urandom),
                    $urandom_range(0, 9) == 0, ROW_CELL, NoResult);
      end
      rand_items += n;
    end

    wait_grid_idle();
    if (mismatches == 0) begin
      $display("grid_block_majority_downsample_unit regression: pass");
    end else begin
      $display("grid_block_majority_downsample_unit regression: fail");
    end
    $finish;
  end

endmodule
